@@ rtl/dvrt_pkg.sv @@
// Shared types and constants for the distance-vector route table.
// Used by dvrt_cell, dvrt_update and the top level; depends on nothing.
package dvrt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [4:0] METRIC_INF = 5'd16;

    localparam logic [1:0] ACT_ADVERT = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_SWEEP  = 2'd2;

    localparam logic [2:0] CODE_NONE    = 3'd0;
    localparam logic [2:0] CODE_INSTALL = 3'd1;
    localparam logic [2:0] CODE_REPLACE = 3'd2;
    localparam logic [2:0] CODE_INVAL   = 3'd3;
    localparam logic [2:0] CODE_IGNORED = 3'd4;
    localparam logic [2:0] CODE_FULL    = 3'd5;

    localparam logic [0:0] REG_INVALID_TIMEOUT = 1'd0;
    localparam logic [0:0] REG_FLUSH_TIMEOUT   = 1'd1;

    typedef struct packed {
        logic        valid;
        logic [31:0] prefix;
        logic [31:0] mask;
        logic [4:0]  metric;
        logic [31:0] neighbour;
        logic [31:0] stamp;
        logic        is_local;
    } entry_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        prefix;
        logic [31:0]        mask;
        logic [4:0]         metric;
        logic [31:0]        neighbour;
        logic [31:0]        stamp;
        logic               is_local;
        logic signed [32:0] exp_t;
        logic signed [32:0] gc_t;
    } req_t;

    // per-entry results of the update unit
    typedef struct packed {
        logic hit;
        logic free;
        logic deleted;
        logic invalidated;
    } upd_flags_t;

    // pass-two write control
    typedef struct packed {
        logic write_pass;
        logic sel;
        logic stamp_only;
    } wr_ctl_t;

endpackage

@@ rtl/dvrt_cell.sv @@
// One table slot of the rotating route ring; hands its entry on each shift.
// Depends on dvrt_pkg.
module dvrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  dvrt_pkg::entry_t din,
    output dvrt_pkg::entry_t dout
);

    logic             valid_reg;
    dvrt_pkg::entry_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

@@ rtl/dvrt_update.sv @@
// Per-entry update unit at the tail of the ring: match, age, sweep and write.
// Depends on dvrt_pkg.
module dvrt_update (
    input  dvrt_pkg::req_t     req,
    input  dvrt_pkg::wr_ctl_t  wr,
    input  dvrt_pkg::entry_t   ein,
    output dvrt_pkg::entry_t   eout,
    output dvrt_pkg::upd_flags_t flags
);

    logic signed [32:0] st;
    logic               pm_eq;

    assign st    = $signed({1'b0, ein.stamp});
    assign pm_eq = ein.valid && (ein.prefix == req.prefix) && (ein.mask == req.mask);

    always_comb
    begin
        eout  = ein;
        flags = '0;
        if (wr.write_pass)
        begin
            if (wr.sel)
            begin
                if (wr.stamp_only)
                begin
                    eout.stamp = req.stamp;
                end
                else
                begin
                    eout.valid     = 1'b1;
                    eout.prefix    = req.prefix;
                    eout.mask      = req.mask;
                    eout.metric    = req.metric;
                    eout.neighbour = req.neighbour;
                    eout.stamp     = req.stamp;
                    eout.is_local  = req.is_local;
                end
            end
        end
        else
        begin
            case (req.action)
                dvrt_pkg::ACT_ADVERT:
                begin
                    flags.free = !ein.valid;
                    if (req.metric == dvrt_pkg::METRIC_INF)
                    begin
                        flags.hit = pm_eq && (ein.neighbour == req.neighbour);
                    end
                    else
                    begin
                        flags.hit = pm_eq;
                    end
                end
                dvrt_pkg::ACT_TICK:
                begin
                    if (ein.valid)
                    begin
                        if ((st < req.exp_t) && (st > req.gc_t) &&
                            (ein.metric < dvrt_pkg::METRIC_INF) && !ein.is_local)
                        begin
                            eout.metric = dvrt_pkg::METRIC_INF;
                        end
                        else if ((st < req.gc_t) && (ein.metric >= dvrt_pkg::METRIC_INF))
                        begin
                            eout.valid    = 1'b0;
                            flags.deleted = 1'b1;
                        end
                    end
                end
                dvrt_pkg::ACT_SWEEP:
                begin
                    if (ein.valid && ein.is_local && (ein.stamp != req.stamp) &&
                        (ein.metric == 5'd0))
                    begin
                        eout.metric       = dvrt_pkg::METRIC_INF;
                        flags.invalidated = 1'b1;
                    end
                end
                default:
                begin
                    eout = ein;
                end
            endcase
        end
    end

endmodule

@@ rtl/distance_vector_route_table.sv @@
// Route table with a ring of TABLE_ENTRIES cells rotating once per pass
// through a single update unit. Expiry ticks and local sweeps take one
// pass over the ring. An advertisement takes a search pass, a decide step
// and, when the table changes, a second write pass. One request is in work
// at a time; the result register frees the input side while it waits.
module distance_vector_route_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // prefix[31:0], mask[63:32], metric[68:64], neighbour[100:69],
    // timestamp[132:101], is_local[133], zero fill
    input  logic [135:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // route_prefix[31:0], route_mask[63:32], route_metric[68:64],
    // route_neighbour[100:69], table_grew[101], deleted_count[108:102],
    // any_invalidated[109], zero fill
    output logic [111:0]  m_tdata,
    // route_code[2:0]
    output logic [2:0]    m_tuser,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [15:0]   cfg_data
);

    localparam int N = dvrt_pkg::TABLE_ENTRIES;
    localparam int W = dvrt_pkg::IDX_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [W-1:0] cnt_reg;
    logic [15:0] inv_to_reg, flush_to_reg;

    dvrt_pkg::req_t req_reg;

    logic         hit_found_reg, free_found_reg;
    logic [W-1:0] hit_pos_reg, free_pos_reg;
    logic [4:0]   hit_metric_reg;
    logic [31:0]  hit_nb_reg;

    logic         wr_pos_sel_hit_reg;
    logic         stamp_only_reg;
    logic [2:0]   code_reg;
    logic         report_reg, grew_reg, anyinv_reg;
    logic [6:0]   del_reg;

    logic         m_tvalid_reg;
    logic [111:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;

    dvrt_pkg::entry_t      ring [N];
    dvrt_pkg::entry_t      upd_out;
    dvrt_pkg::upd_flags_t  flags;
    dvrt_pkg::wr_ctl_t     wr;
    logic                  shift;
    logic                  last;
    logic                  accept;
    logic [4:0]            in_metric;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign shift    = (state_reg == ST_SCAN) || (state_reg == ST_WRITE);
    assign last     = (cnt_reg == W'(N - 1));
    assign in_metric = (s_tdata[68:64] > dvrt_pkg::METRIC_INF) ?
                       dvrt_pkg::METRIC_INF : s_tdata[68:64];

    assign wr.write_pass = (state_reg == ST_WRITE);
    assign wr.sel        = (cnt_reg == (wr_pos_sel_hit_reg ? hit_pos_reg : free_pos_reg));
    assign wr.stamp_only = stamp_only_reg;

    // ring: cell 0 is fed by the update unit, the last cell feeds it
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            dvrt_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   ((g == 0) ? upd_out : ring[(g == 0) ? 0 : g - 1]),
                .dout  (ring[g])
            );
        end
    endgenerate

    dvrt_update u_update (
        .req   (req_reg),
        .wr    (wr),
        .ein   (ring[N-1]),
        .eout  (upd_out),
        .flags (flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_to_reg   <= 16'd180;
            flush_to_reg <= 16'd300;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dvrt_pkg::REG_INVALID_TIMEOUT: inv_to_reg   <= cfg_data;
                dvrt_pkg::REG_FLUSH_TIMEOUT:   flush_to_reg <= cfg_data;
                default:                       inv_to_reg   <= inv_to_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == dvrt_pkg::ACT_ADVERT || s_tuser == dvrt_pkg::ACT_TICK ||
                        s_tuser == dvrt_pkg::ACT_SWEEP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = (req_reg.action == dvrt_pkg::ACT_ADVERT) ? ST_DECIDE : ST_DONE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_DONE;
                if (req_reg.metric == dvrt_pkg::METRIC_INF)
                begin
                    if (hit_found_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else if (hit_found_reg)
                begin
                    if ((req_reg.metric < hit_metric_reg) ||
                        ((req_reg.metric == hit_metric_reg) &&
                         (req_reg.neighbour == hit_nb_reg)))
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else if (free_found_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift)
            begin
                cnt_reg <= last ? '0 : cnt_reg + W'(1);
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.action    <= s_tuser;
            req_reg.prefix    <= s_tdata[31:0];
            req_reg.mask      <= s_tdata[63:32];
            req_reg.metric    <= in_metric;
            req_reg.neighbour <= s_tdata[100:69];
            req_reg.stamp     <= s_tdata[132:101];
            req_reg.is_local  <= s_tdata[133];
            req_reg.exp_t     <= $signed({1'b0, s_tdata[132:101]}) -
                                 $signed({17'd0, inv_to_reg});
            req_reg.gc_t      <= $signed({1'b0, s_tdata[132:101]}) -
                                 $signed({17'd0, flush_to_reg});
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            code_reg       <= dvrt_pkg::CODE_NONE;
            report_reg     <= 1'b0;
            grew_reg       <= 1'b0;
            anyinv_reg     <= 1'b0;
            del_reg        <= 7'd0;
        end
        if (state_reg == ST_SCAN)
        begin
            // entries leave the ring highest index first, so the last one
            // seen is the lowest-numbered slot
            if (flags.hit)
            begin
                hit_found_reg  <= 1'b1;
                hit_pos_reg    <= cnt_reg;
                hit_metric_reg <= ring[N-1].metric;
                hit_nb_reg     <= ring[N-1].neighbour;
            end
            if (flags.free)
            begin
                free_found_reg <= 1'b1;
                free_pos_reg   <= cnt_reg;
            end
            if (flags.deleted && del_reg != 7'd127)
            begin
                del_reg <= del_reg + 7'd1;
            end
            if (flags.invalidated)
            begin
                anyinv_reg <= 1'b1;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            wr_pos_sel_hit_reg <= hit_found_reg;
            stamp_only_reg     <= 1'b0;
            if (req_reg.metric == dvrt_pkg::METRIC_INF)
            begin
                code_reg   <= hit_found_reg ? dvrt_pkg::CODE_INVAL : dvrt_pkg::CODE_IGNORED;
                report_reg <= hit_found_reg;
            end
            else if (hit_found_reg)
            begin
                if (req_reg.metric < hit_metric_reg)
                begin
                    code_reg   <= (hit_metric_reg == dvrt_pkg::METRIC_INF) ?
                                  dvrt_pkg::CODE_INSTALL : dvrt_pkg::CODE_REPLACE;
                    report_reg <= 1'b1;
                end
                else
                begin
                    stamp_only_reg <= 1'b1;
                end
            end
            else if (free_found_reg)
            begin
                code_reg   <= dvrt_pkg::CODE_INSTALL;
                report_reg <= 1'b1;
                grew_reg   <= 1'b1;
            end
            else
            begin
                code_reg <= dvrt_pkg::CODE_FULL;
            end
        end
        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_tuser_reg <= code_reg;
            m_tdata_reg <= {2'b00, anyinv_reg, del_reg, grew_reg,
                            report_reg ? req_reg.neighbour : 32'd0,
                            report_reg ? req_reg.metric : 5'd0,
                            report_reg ? req_reg.mask : 32'd0,
                            report_reg ? req_reg.prefix : 32'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/dvrt_checker.sv @@
// Port-level checks for distance_vector_route_table, attached by bind.
// Depends on dvrt_pkg for the result codes.
module dvrt_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= dvrt_pkg::CODE_FULL)
        else $error("result code out of range");

    a_grew_install: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[101] |-> m_tuser == dvrt_pkg::CODE_INSTALL)
        else $error("table grew without an install");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
